// ===== rtl/microwire_serial_eeprom_defines.svh =====
// assertion macros shared by the eeprom rtl
`ifndef MICROWIRE_SERIAL_EEPROM_DEFINES_SVH
`define MICROWIRE_SERIAL_EEPROM_DEFINES_SVH

// condition implies consequence in the same cycle
`define MWE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define MWE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mwe_pkg.sv =====
package mwe_pkg;

  localparam int unsigned WORD_W    = 16;
  localparam int unsigned ADDR_W    = 8;
  localparam int unsigned NUM_WORDS = 256;
  localparam int unsigned CNT_W     = 5;

  localparam logic [WORD_W-1:0] MSB_MASK = 16'h8000;

  // supported address widths
  localparam logic [3:0] ABITS_4 = 4'd4;
  localparam logic [3:0] ABITS_6 = 4'd6;
  localparam logic [3:0] ABITS_8 = 4'd8;

  typedef enum logic [1:0] {
    OPC_EXT   = 2'd0,
    OPC_WRITE = 2'd1,
    OPC_READ  = 2'd2,
    OPC_ERASE = 2'd3
  } opc_t;

  typedef enum logic [1:0] {
    EXT_WDS  = 2'd0,
    EXT_WRAL = 2'd1,
    EXT_ERAL = 2'd2,
    EXT_WEN  = 2'd3
  } ext_t;

  // request from the frame decoder to the word store
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic              clr_one;
    logic              clr_all;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] size_mask;
  } st_req_t;

endpackage

// ===== rtl/microwire_serial_eeprom.sv =====
// a pin sample beat yields its data-out beat in the cycle after acceptance
// throughput: one sample per cycle while the receiver takes output beats; a word read issued at
//   the end of the address is taken from the store's registered port in the following cycle
// erase all clears the per-word valid bits of every word in the address range together, so it never stalls
// reset (rst_n low, synchronous) makes every word read zero and clears the frame state and write protect
module microwire_serial_eeprom (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [0] chip_select, [1] serial_clock, [2] data_in
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] data_out
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);
  import mwe_pkg::*;

  logic              acc;
  logic              dout;
  logic [3:0]        abits_r;
  logic              out_valid_r;
  logic              out_bit_r;
  st_req_t           req;
  logic [WORD_W-1:0] rd_word;

  // input beat taken whenever the output register is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  // address width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abits_r <= ABITS_6;
    end else if (cfg_wr_en) begin
      abits_r <= cfg_wr_data;
    end
  end

  mwe_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .cs        (in_tdata[0]),
    .sk        (in_tdata[1]),
    .di        (in_tdata[2]),
    .cfg_abits (abits_r),
    .rd_word   (rd_word),
    .req       (req),
    .dout      (dout)
  );

  mwe_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_word (rd_word)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_bit_r <= dout;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_bit_r};

endmodule

// ===== rtl/mwe_store.sv =====
`include "microwire_serial_eeprom_defines.svh"

module mwe_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mwe_pkg::st_req_t            req,
  output logic [mwe_pkg::WORD_W-1:0]  rd_word
);
  import mwe_pkg::*;

  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [WORD_W-1:0]    q_r;
  logic                 vq_r;
  logic [NUM_WORDS-1:0] vld_r;
  logic [NUM_WORDS-1:0] vld_nxt;

  // word array, one write and one registered read port
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      q_r <= mem[req.addr];
    end
  end

  // valid bits: an entry never written or erased reads as zero
  always_comb begin
    vld_nxt = vld_r;
    if (req.clr_all) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        if ((ADDR_W'(i) & ~req.size_mask) == '0) begin
          vld_nxt[i] = 1'b0;
        end
      end
    end
    if (req.clr_one) begin
      vld_nxt[req.addr] = 1'b0;
    end
    if (req.wr) begin
      vld_nxt[req.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      vq_r  <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (req.rd) begin
        vq_r <= vld_r[req.addr];
      end
    end
  end

  assign rd_word = vq_r ? q_r : '0;

  `MWE_ASSERT_NOW(a_one_op, req.rd, !req.wr && !req.clr_one && !req.clr_all, "read collides with an update")
  `MWE_ASSERT_NEXT(a_wr_valid, rst_n && req.wr, vld_r[$past(req.addr)], "written word not marked valid")
  `MWE_ASSERT_NEXT(a_clr_all, rst_n && req.clr_all, !vld_r[0], "erase all left word zero valid")

endmodule

// ===== rtl/mwe_frame.sv =====
module mwe_frame (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  logic                        cs,
  input  logic                        sk,
  input  logic                        di,
  input  logic [3:0]                  cfg_abits,
  input  logic [mwe_pkg::WORD_W-1:0]  rd_word,
  output mwe_pkg::st_req_t            req,
  output logic                        dout
);
  import mwe_pkg::*;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  opc_t              opc_r, opc_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [WORD_W-1:0] data_r, data_nxt;
  logic              wp_r, wp_nxt;
  logic              last_cs_r, last_sk_r;
  logic              obit_r, obit_nxt;
  logic              ld_pend_r, ld_pend_nxt;

  logic [3:0]        abits;
  logic [CNT_W-1:0]  addr_end;
  logic [CNT_W-1:0]  data_end;
  logic [CNT_W-1:0]  cnt_inc;
  logic [WORD_W-1:0] data_cur;
  logic [ADDR_W-1:0] ash;
  logic [ADDR_W-1:0] amask;
  logic [ADDR_W-1:0] addr_m;
  ext_t              sub;

  // effective address width, unsupported codes act as six
  always_comb begin
    abits = ABITS_6;
    if (cfg_abits == ABITS_4 || cfg_abits == ABITS_8) begin
      abits = cfg_abits;
    end
  end

  assign addr_end = CNT_W'(4) + CNT_W'(abits);
  assign data_end = addr_end + CNT_W'(WORD_W);
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign ash      = {addr_r[ADDR_W-2:0], di};

  // word read last cycle is taken here
  assign data_cur = ld_pend_r ? rd_word : data_r;

  // address mask and extended-command selector per width
  always_comb begin
    case (abits)
      ABITS_4: amask = 8'h0F;
      ABITS_8: amask = 8'hFF;
      default: amask = 8'h3F;
    endcase
    addr_m = ash & amask;
    case (abits)
      ABITS_4: sub = ext_t'(addr_m[3:2]);
      ABITS_8: sub = ext_t'(addr_m[7:6]);
      default: sub = ext_t'(addr_m[5:4]);
    endcase
  end

  // frame decode for one pin sample
  always_comb begin
    cnt_nxt     = cnt_r;
    opc_nxt     = opc_r;
    addr_nxt    = addr_r;
    data_nxt    = data_cur;
    wp_nxt      = wp_r;
    obit_nxt    = obit_r;
    ld_pend_nxt = 1'b0;
    req         = '0;
    req.addr      = addr_r;
    req.wdata     = data_cur;
    req.size_mask = amask;
    if (acc) begin
      if (!last_cs_r && cs) begin
        cnt_nxt  = '0;
        opc_nxt  = OPC_EXT;
        addr_nxt = '0;
        obit_nxt = 1'b1;
      end else if (cs && !last_sk_r && sk) begin
        if (cnt_r == CNT_W'(0)) begin
          if (!di) begin
            cnt_nxt = CNT_W'(1);
          end
        end else if (cnt_r == CNT_W'(1)) begin
          if (di) begin
            cnt_nxt = CNT_W'(2);
          end
        end else if (cnt_r < CNT_W'(4)) begin
          cnt_nxt = cnt_inc;
          opc_nxt = opc_t'({opc_r[0], di});
        end else if (cnt_r < addr_end) begin
          cnt_nxt  = cnt_inc;
          addr_nxt = ash;
          if (cnt_inc == addr_end) begin
            addr_nxt = addr_m;
            obit_nxt = 1'b0;
            req.addr = addr_m;
            case (opc_r)
              OPC_EXT: begin
                case (sub)
                  EXT_WDS:  wp_nxt = 1'b1;
                  EXT_ERAL: req.clr_all = 1'b1;
                  EXT_WEN:  wp_nxt = 1'b0;
                  default:  ;
                endcase
              end
              OPC_ERASE: req.clr_one = 1'b1;
              default: begin
                req.rd      = 1'b1;
                ld_pend_nxt = 1'b1;
              end
            endcase
          end
        end else if (cnt_r < data_end) begin
          cnt_nxt = cnt_inc;
          case (opc_r)
            OPC_WRITE: begin
              data_nxt  = {data_cur[WORD_W-2:0], di};
              req.wdata = data_nxt;
              if (cnt_inc == data_end && !wp_r) begin
                req.wr = 1'b1;
              end
            end
            OPC_READ: begin
              obit_nxt = (data_cur & MSB_MASK) != '0;
              data_nxt = {data_cur[WORD_W-2:0], 1'b0};
            end
            default: ;
          endcase
        end
      end
    end
  end

  assign dout = cs & obit_nxt;

  // frame registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      opc_r     <= OPC_EXT;
      addr_r    <= '0;
      data_r    <= '0;
      wp_r      <= 1'b0;
      last_cs_r <= 1'b0;
      last_sk_r <= 1'b0;
      obit_r    <= 1'b0;
      ld_pend_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      opc_r     <= opc_nxt;
      addr_r    <= addr_nxt;
      data_r    <= data_nxt;
      wp_r      <= wp_nxt;
      obit_r    <= obit_nxt;
      ld_pend_r <= ld_pend_nxt;
      if (acc) begin
        last_cs_r <= cs;
        last_sk_r <= sk;
      end
    end
  end

endmodule

// ===== tb/sv/microwire_serial_eeprom_test.sv =====
`timescale 1ns / 100ps

module microwire_serial_eeprom_test;
  import mwe_pkg::*;

  // stimulus table rows: a single pin sample, a whole frame, or a width write
  typedef enum logic [1:0] {ROW_PINS, ROW_FRAME, ROW_WIDTH} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [3:0]  width;
    opc_t        op;
    logic [7:0]  addr;
    logic [15:0] word;
    logic [2:0]  pins;   // {data_in, serial_clock, chip_select}
    logic        junk;   // stray start bit and extra zero before the start
    logic        known;  // expected data-out typed in below
    logic [15:0] kword;  // pin level, or the word a read shifts out
  } plan_row_t;

  typedef enum int {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_HEAVY} rx_mode_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [0] chip_select, [1] serial_clock, [2] data_in
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [0] data_out
  logic       cfg_wr_en = 1'b0;
  logic [3:0] cfg_wr_data = 4'd0;

  // expectation pinned to the beat on the bus, travels with in_tdata
  logic pin_known = 1'b0;
  logic pin_bit = 1'b0;

  // predicted data-out levels still to arrive
  logic want_dout_q[$];
  int   mismatches = 0;
  int   pins_sent = 0;
  int   burst_left = 0;
  bit   noisy = 1'b0;

  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;

  // predictor state
  logic [3:0]  width_reg;
  logic [4:0]  fr_count;
  logic [1:0]  fr_opc;
  logic [7:0]  fr_addr;
  logic [15:0] fr_shift;
  logic        wr_locked;
  logic        prev_cs;
  logic        prev_sk;
  logic        dout_reg;
  logic [15:0] words [256];

  plan_row_t plan [25] = '{
    // deselected level, select raises data-out, a stray start bit is ignored
    '{ROW_PINS,  4'd0,    OPC_EXT,   8'h00, 16'h0000, 3'b110, 1'b0, 1'b1, 16'h0000},
    '{ROW_PINS,  4'd0,    OPC_EXT,   8'h00, 16'h0000, 3'b001, 1'b0, 1'b1, 16'h0001},
    '{ROW_PINS,  4'd0,    OPC_EXT,   8'h00, 16'h0000, 3'b111, 1'b0, 1'b1, 16'h0001},
    '{ROW_PINS,  4'd0,    OPC_EXT,   8'h00, 16'h0000, 3'b000, 1'b0, 1'b1, 16'h0000},
    // six-bit width: cleared store, full word, write protect, erase while protected
    '{ROW_FRAME, 4'd0,    OPC_READ,  8'h00, 16'h0000, 3'b000, 1'b0, 1'b1, 16'h0000},
    '{ROW_FRAME, 4'd0,    OPC_WRITE, 8'h3F, 16'hFFFF, 3'b000, 1'b0, 1'b0, 16'h0000},
    '{ROW_FRAME, 4'd0,    OPC_READ,  8'h3F, 16'h0000, 3'b000, 1'b0, 1'b1, 16'hFFFF},
    '{ROW_FRAME, 4'd0,    OPC_EXT,   8'h00, 16'h0000, 3'b000, 1'b0, 1'b0, 16'h0000},
    '{ROW_FRAME, 4'd0,    OPC_WRITE, 8'h3F, 16'h1234, 3'b000, 1'b0, 1'b0, 16'h0000},
    '{ROW_FRAME, 4'd0,    OPC_READ,  8'h3F, 16'h0000, 3'b000, 1'b0, 1'b1, 16'hFFFF},
    '{ROW_FRAME, 4'd0,    OPC_ERASE, 8'h3F, 16'h0000, 3'b000, 1'b0, 1'b0, 16'h0000},
    '{ROW_FRAME, 4'd0,    OPC_READ,  8'h3F, 16'h0000, 3'b000, 1'b0, 1'b1, 16'h0000},
    '{ROW_FRAME, 4'd0,    OPC_EXT,   8'h30, 16'h0000, 3'b000, 1'b0, 1'b0, 16'h0000},
    '{ROW_FRAME, 4'd0,    OPC_WRITE, 8'h00, 16'hA5C3, 3'b000, 1'b1, 1'b0, 16'h0000},
    // four-bit width: write all does nothing, erase all clears
    '{ROW_WIDTH, ABITS_4, OPC_EXT,   8'h00, 16'h0000, 3'b000, 1'b0, 1'b0, 16'h0000},
    '{ROW_FRAME, 4'd0,    OPC_WRITE, 8'h0F, 16'h8001, 3'b000, 1'b0, 1'b0, 16'h0000},
    '{ROW_FRAME, 4'd0,    OPC_EXT,   8'h04, 16'h0000, 3'b000, 1'b0, 1'b0, 16'h0000},
    '{ROW_FRAME, 4'd0,    OPC_READ,  8'h00, 16'h0000, 3'b000, 1'b0, 1'b1, 16'hA5C3},
    '{ROW_FRAME, 4'd0,    OPC_EXT,   8'h08, 16'h0000, 3'b000, 1'b0, 1'b0, 16'h0000},
    '{ROW_FRAME, 4'd0,    OPC_READ,  8'h0F, 16'h0000, 3'b000, 1'b0, 1'b1, 16'h0000},
    // eight-bit width, top word
    '{ROW_WIDTH, ABITS_8, OPC_EXT,   8'h00, 16'h0000, 3'b000, 1'b0, 1'b0, 16'h0000},
    '{ROW_FRAME, 4'd0,    OPC_WRITE, 8'hFF, 16'h7FFE, 3'b000, 1'b0, 1'b0, 16'h0000},
    '{ROW_FRAME, 4'd0,    OPC_READ,  8'hFF, 16'h0000, 3'b000, 1'b0, 1'b0, 16'h0000},
    // unsupported width behaves as six bits
    '{ROW_WIDTH, 4'd0,    OPC_EXT,   8'h00, 16'h0000, 3'b000, 1'b0, 1'b0, 16'h0000},
    '{ROW_FRAME, 4'd0,    OPC_READ,  8'h3F, 16'h0000, 3'b000, 1'b0, 1'b0, 16'h0000}
  };

  // widths for the random phases, both extremes of the register included
  logic [3:0] width_plan [9] = '{ABITS_8, ABITS_4, 4'd15, ABITS_6, 4'd0, ABITS_4, 4'd9,
                                 ABITS_8, 4'd5};

  microwire_serial_eeprom u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // effective address width, odd register values fall back to six
  function automatic int eff_width();
    if (width_reg == ABITS_4 || width_reg == ABITS_8) return int'(width_reg);
    return int'(ABITS_6);
  endfunction

  function automatic void eeprom_reset();
    width_reg = ABITS_6;
    fr_count = '0;
    fr_opc = OPC_EXT;
    fr_addr = '0;
    fr_shift = '0;
    wr_locked = 1'b0;
    prev_cs = 1'b0;
    prev_sk = 1'b0;
    dout_reg = 1'b0;
    foreach (words[i]) words[i] = '0;
  endfunction

  // last address bit in: dummy zero, then run the command
  function automatic void finish_address(input int w);
    logic [7:0] mask;
    ext_t sub;
    mask = 8'((1 << w) - 1);
    fr_addr = fr_addr & mask;
    dout_reg = 1'b0;
    case (fr_opc)
      OPC_EXT: begin
        sub = ext_t'(2'((32'(fr_addr) >> (w - 2)) & 3));
        case (sub)
          EXT_WDS:  wr_locked = 1'b1;
          EXT_WRAL: ;
          EXT_ERAL: for (int i = 0; i <= int'(mask); i++) words[i] = '0;
          EXT_WEN:  wr_locked = 1'b0;
        endcase
      end
      OPC_ERASE: words[fr_addr] = '0;
      default:   fr_shift = words[fr_addr];
    endcase
  endfunction

  // one rising serial clock while selected
  function automatic void take_edge(input logic di);
    int w;
    int addr_end;
    int data_end;
    w = eff_width();
    addr_end = 4 + w;
    data_end = addr_end + 16;
    if (fr_count == 0) begin
      if (!di) fr_count = 5'd1;
    end else if (fr_count == 1) begin
      if (di) fr_count = 5'd2;
    end else if (fr_count < 4) begin
      fr_count++;
      fr_opc = {fr_opc[0], di};
    end else if (fr_count < addr_end) begin
      fr_count++;
      fr_addr = {fr_addr[6:0], di};
      if (fr_count == addr_end) finish_address(w);
    end else if (fr_count < data_end) begin
      fr_count++;
      if (fr_opc == OPC_WRITE) begin
        fr_shift = {fr_shift[14:0], di};
        if (fr_count == data_end && !wr_locked) words[fr_addr] = fr_shift;
      end else if (fr_opc == OPC_READ) begin
        dout_reg = (fr_shift & MSB_MASK) != '0;
        fr_shift = fr_shift << 1;
      end
    end
  endfunction

  // one pin sample in, data-out level after it
  function automatic logic eeprom_step(input logic cs, input logic sk, input logic di);
    if (!prev_cs && cs) begin
      fr_count = '0;
      fr_opc = OPC_EXT;
      fr_addr = '0;
      dout_reg = 1'b1;
    end else if (cs && !prev_sk && sk) begin
      take_edge(di);
    end
    prev_cs = cs;
    prev_sk = sk;
    return cs && dout_reg;
  endfunction

  // predict on accepted input beats, check accepted output beats
  always @(posedge clk) begin : scoreboard
    logic got;
    logic want;
    if (rst_n) begin
      if (cfg_wr_en) width_reg = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        got = eeprom_step(in_tdata[0], in_tdata[1], in_tdata[2]);
        want_dout_q.push_back(pin_known ? pin_bit : got);
      end
      if (out_tvalid && out_tready) begin
        if (want_dout_q.size() == 0) begin
          $display("%0t: data_out expected none got %0b", $time, out_tdata[0]);
          mismatches++;
        end else begin
          want = want_dout_q.pop_front();
          if (out_tdata[0] !== want) begin
            $display("%0t: data_out expected %0b got %0b", $time, want, out_tdata[0]);
            mismatches++;
          end
        end
      end
    end
  end

  // receiver stalls: modes held for random stretches
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     out_tready <= 1'b1;
      RX_SPARSE:   out_tready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: out_tready <= (rx_tick % 5 != 2);
      default:     out_tready <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // one pin sample beat, sent in bursts with random gaps
  task automatic send_pins(input logic cs, input logic sk, input logic di,
                           input logic k, input logic b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, di, sk, cs};
    pin_known <= k;
    pin_bit <= b;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    pins_sent++;
  endtask

  // one serial clock period with chip select high
  task automatic send_edge(input logic di, input logic k, input logic b);
    int lows;
    int holds;
    lows = (noisy && $urandom_range(0, 3) == 0) ? 2 : 1;
    holds = (noisy && $urandom_range(0, 3) == 0) ? 1 : 0;
    repeat (lows) send_pins(1'b1, 1'b0, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
    send_pins(1'b1, 1'b1, di, k, b);
    repeat (holds) send_pins(1'b1, 1'b1, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
  endtask

  // deselect, select, then the frame bits; stops after cut edges
  task automatic send_frame(input opc_t op, input logic [7:0] addr, input logic [15:0] word,
                            input logic junk, input int cut, input logic known,
                            input logic [15:0] kword);
    logic bits_q[$];
    logic [1:0] opb;
    int w;
    int data_at;
    w = eff_width();
    opb = op;
    send_pins(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
    send_pins(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
    if (junk) bits_q = '{1'b1, 1'b0, 1'b0, 1'b1};
    else bits_q = '{1'b0, 1'b1};
    bits_q.push_back(opb[1]);
    bits_q.push_back(opb[0]);
    for (int j = w - 1; j >= 0; j--) bits_q.push_back(addr[j]);
    data_at = bits_q.size();
    if (op == OPC_WRITE || op == OPC_READ) begin
      for (int j = 15; j >= 0; j--)
        bits_q.push_back(op == OPC_WRITE ? word[j] : 1'($urandom_range(0, 1)));
    end
    for (int j = 0; j < bits_q.size() && j < cut; j++)
      send_edge(bits_q[j], known && j >= data_at,
                (j >= data_at) ? kword[15 - (j - data_at)] : 1'b0);
  endtask

  // well-formed frame with random command, address and word
  task automatic send_random_frame(input int cut);
    opc_t op;
    ext_t sub;
    logic [7:0] addr;
    logic [15:0] word;
    int w;
    int r;
    w = eff_width();
    r = $urandom_range(0, 99);
    if (r < 35) op = OPC_WRITE;
    else if (r < 70) op = OPC_READ;
    else if (r < 80) op = OPC_ERASE;
    else op = OPC_EXT;
    // low words, top words, or anywhere
    r = $urandom_range(0, 2);
    if (r == 0) addr = 8'($urandom_range(0, 3));
    else if (r == 1) addr = 8'((1 << w) - 1 - $urandom_range(0, 1));
    else addr = 8'($urandom);
    if (op == OPC_EXT) begin
      r = $urandom_range(0, 9);
      if (r < 2) sub = EXT_WDS;
      else if (r < 4) sub = EXT_WRAL;
      else if (r < 5) sub = EXT_ERAL;
      else sub = EXT_WEN;
      addr = 8'((32'(sub) << (w - 2)) | (32'(addr) & ((32'd1 << (w - 2)) - 1)));
    end
    r = $urandom_range(0, 7);
    if (r == 0) word = 16'h0000;
    else if (r == 1) word = 16'hFFFF;
    else word = 16'($urandom);
    send_frame(op, addr, word, $urandom_range(0, 7) == 0, cut, 1'b0, 16'h0000);
  endtask

  // wait until every predicted beat has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (want_dout_q.size() != 0);
  endtask

  // width write, returns once the predictor holds the new width
  task automatic set_width(input logic [3:0] w);
    drain();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int target;
    int r;
    eeprom_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_PINS:  send_pins(plan[i].pins[0], plan[i].pins[1], plan[i].pins[2],
                             plan[i].known, plan[i].kword[0]);
        ROW_WIDTH: set_width(plan[i].width);
        default:   send_frame(plan[i].op, plan[i].addr, plan[i].word, plan[i].junk, 64,
                              plan[i].known, plan[i].kword);
      endcase
    end

    // random phases, one width each
    noisy = 1'b1;
    foreach (width_plan[p]) begin
      set_width(width_plan[p]);
      // carry on an open frame under the new width
      repeat ($urandom_range(0, 10)) send_edge(1'($urandom_range(0, 1)), 1'b0, 1'b0);
      target = pins_sent + 60;
      while (pins_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          repeat ($urandom_range(1, 6))
            send_pins(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b0, 1'b0);
        end else if (r < 18) begin
          send_random_frame($urandom_range(1, 20));
        end else begin
          send_random_frame(64);
          // edges past the end of the frame
          if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 4)) send_edge(1'($urandom_range(0, 1)), 1'b0, 1'b0);
        end
      end
      // sometimes leave a frame open across the width change
      if ($urandom_range(0, 1) == 1) send_random_frame($urandom_range(3, 12));
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mwe_pkg.sv
rtl/mwe_store.sv
rtl/mwe_frame.sv
rtl/microwire_serial_eeprom.sv
tb/sv/microwire_serial_eeprom_test.sv
